@@ rtl/core/assert_macros.svh @@
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define CHK_IMPLY(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("check failed");
`endif

@@ rtl/core/dlrc_pkg.sv @@
`timescale 1ns / 1ps
package dlrc_pkg;
	localparam logic [2:0] CMD_OFF = 3'd0;
	localparam logic [2:0] CMD_ON = 3'd1;
	localparam logic [2:0] CMD_TOGGLE = 3'd2;
	localparam logic [2:0] CMD_MOVE_TO = 3'd3;
	localparam logic [2:0] CMD_MOVE = 3'd4;
	localparam logic [2:0] CMD_STEP = 3'd5;
	localparam logic [2:0] CMD_STOP = 3'd6;
	localparam logic [2:0] CMD_TICK = 3'd7;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_EP = 2'd1;
	localparam logic [7:0] LEVEL_KEEP = 8'hFF;
	localparam logic [7:0] LEVEL_MAX = 8'd254;
	localparam logic [7:0] LEVEL_MIN = 8'd1;
	localparam logic [15:0] IV_MIN = 16'd10;
	localparam logic [15:0] RATE_NUM = 16'd1000;
	localparam int MAX_RES = 6;

	typedef enum logic [3:0] {
		S_IDLE, S_BAD, S_CMD, S_DIV, S_SETUP, S_RESULT,
		S_TICK, S_TICK_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic cap;      // capture the transaction fields
		logic exec;     // apply off/on/toggle/stop, compute move target
		logic div_go;   // start divider
		logic setup;    // load ramp after divide
		logic tick_ch;  // advance the selected channel
		logic emit;     // drive one result
		logic emit_bad;
		logic emit_last;
	} ctl_t;

	typedef struct packed {
		logic div_busy;
		logic need_div;
	} sts_t;
endpackage

@@ rtl/core/dimmer_level_ramp_controller_top.sv @@
`timescale 1ns / 1ps
// After acceptance: bad endpoint S_BAD; off/on/toggle/stop S_CMD, S_RESULT; move, step,
// move-to-level S_CMD, S_DIV (24-bit serial divider), S_SETUP, S_RESULT, where step and
// move-to-level skip S_DIV and S_SETUP at zero distance; the result is then registered.
// A tick walks the channels one per cycle, then reports up to MAX_RES of them from channel 0.
// One transaction at a time; busy drops as the last result strobes. Results cannot be stalled.
// Reset (arst_n low): all channels at level 254, off, no ramps; on_level 255.
module dimmer_level_ramp_controller_top #(
	parameter int CHANNELS = 6,
	parameter int FIRST_ENDPOINT = 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [7:0]  endpoint,
	input  logic [7:0]  target_level,
	input  logic [15:0] transition_time,
	input  logic        direction_up,
	input  logic [7:0]  move_rate,
	input  logic [7:0]  step_size,
	input  logic        with_on_off,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [2:0]  channel,
	output logic [7:0]  level,
	output logic        on_off,
	output logic        last
);
	import dlrc_pkg::*;
	`include "assert_macros.svh"
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	ctl_t ctl;
	sts_t sts;
	logic [CW-1:0] sel;
	logic ep_ok;

	dlrc_ctrl #(.CHANNELS(CHANNELS), .CW(CW)) u_ctrl (.clk(clk), .arst_n(arst_n),
		.start(start), .cmd(cmd), .ep_ok(ep_ok), .sts(sts), .ctl(ctl), .sel(sel),
		.busy(busy));

	dlrc_dp #(.CHANNELS(CHANNELS), .FIRST_ENDPOINT(FIRST_ENDPOINT), .CW(CW)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sel(sel), .cmd(cmd),
		.endpoint(endpoint), .target_level(target_level),
		.transition_time(transition_time), .direction_up(direction_up),
		.move_rate(move_rate), .step_size(step_size), .with_on_off(with_on_off),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .ep_ok(ep_ok), .sts(sts),
		.res_valid(strobe), .res_status(status), .res_channel(channel),
		.res_level(level), .res_on_off(on_off), .res_last(last));

	`CHK_NEXT(a_emit_strobe, ctl.emit, strobe)
	`CHK_IMPLY(a_one_ctl, 1'b1, $onehot0({ctl.cap, ctl.exec, ctl.setup, ctl.tick_ch, ctl.emit}))
	`CHK_NEXT(a_start_busy, start && !busy, busy)
endmodule

@@ rtl/core/dlrc_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle
module dlrc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [23:0] num,
	input  logic [15:0] den,
	output logic        busy,
	output logic [23:0] quo
);
	import dlrc_pkg::*;
	logic [4:0]  cnt_q;
	logic [23:0] q_q;
	logic [16:0] r_q;
	logic [15:0] d_q;
	logic [16:0] trial;
	logic [16:0] rsh;

	assign rsh   = {r_q[15:0], q_q[23]};
	assign trial = rsh - {1'b0, d_q};
	assign busy  = (cnt_q != 5'd0);
	assign quo   = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (go) begin
			cnt_q <= 5'd24;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num;
			r_q <= 17'd0;
			d_q <= den;
		end else if (busy) begin
			if (!trial[16]) begin
				r_q <= trial;
				q_q <= {q_q[22:0], 1'b1};
			end else begin
				r_q <= rsh;
				q_q <= {q_q[22:0], 1'b0};
			end
		end
	end
endmodule

@@ rtl/core/dlrc_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: command decode, divide wait, tick channel walk, result pacing
module dlrc_ctrl #(
	parameter int CHANNELS = 6,
	parameter int CW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         cmd,
	input  logic               ep_ok,
	input  dlrc_pkg::sts_t     sts,
	output dlrc_pkg::ctl_t     ctl,
	output logic [CW-1:0]      sel,
	output logic               busy
);
	import dlrc_pkg::*;
	localparam int NRES = (CHANNELS < MAX_RES) ? CHANNELS : MAX_RES;
	state_t st_q, st_d;
	logic [CW-1:0] sel_q;
	logic [CW-1:0] sel_d;

	assign sel  = sel_q;
	assign busy = (st_q != S_IDLE);

	// next state
	always_comb begin
		st_d  = st_q;
		sel_d = sel_q;
		case (st_q)
			S_IDLE: begin
				sel_d = '0;
				if (start) begin
					if (cmd == CMD_TICK) st_d = S_TICK;
					else if (!ep_ok) st_d = S_BAD;
					else st_d = S_CMD;
				end
			end
			S_BAD: st_d = S_IDLE;
			S_CMD: st_d = sts.need_div ? S_DIV : S_RESULT;
			S_DIV: if (!sts.div_busy) st_d = S_SETUP;
			S_SETUP: st_d = S_RESULT;
			S_RESULT: st_d = S_IDLE;
			S_TICK: begin
				if (sel_q == CW'(CHANNELS - 1)) begin
					sel_d = '0;
					st_d  = S_TICK_OUT;
				end else begin
					sel_d = sel_q + 1'b1;
				end
			end
			S_TICK_OUT: begin
				if (sel_q == CW'(NRES - 1)) st_d = S_IDLE;
				else sel_d = sel_q + 1'b1;
			end
			default: st_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl = '0;
		case (st_q)
			S_IDLE: ctl.cap = start;
			S_BAD: begin
				ctl.emit = 1'b1;
				ctl.emit_bad = 1'b1;
				ctl.emit_last = 1'b1;
			end
			S_CMD: begin
				ctl.exec = 1'b1;
				ctl.div_go = sts.need_div;
			end
			S_DIV: ctl.setup = !sts.div_busy;
			S_RESULT: begin
				ctl.emit = 1'b1;
				ctl.emit_last = 1'b1;
			end
			S_TICK: ctl.tick_ch = 1'b1;
			S_TICK_OUT: begin
				ctl.emit = 1'b1;
				ctl.emit_last = (sel_q == CW'(NRES - 1));
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			sel_q <= '0;
		end else begin
			st_q  <= st_d;
			sel_q <= sel_d;
		end
	end
endmodule

@@ rtl/core/dlrc_dp.sv @@
`timescale 1ns / 1ps
// Channel state and ramp arithmetic
module dlrc_dp #(
	parameter int CHANNELS = 6,
	parameter int FIRST_ENDPOINT = 1,
	parameter int CW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dlrc_pkg::ctl_t     ctl,
	input  logic [CW-1:0]      sel,
	input  logic [2:0]         cmd,
	input  logic [7:0]         endpoint,
	input  logic [7:0]         target_level,
	input  logic [15:0]        transition_time,
	input  logic               direction_up,
	input  logic [7:0]         move_rate,
	input  logic [7:0]         step_size,
	input  logic               with_on_off,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	output logic               ep_ok,
	output dlrc_pkg::sts_t     sts,
	output logic               res_valid,
	output logic [1:0]         res_status,
	output logic [2:0]         res_channel,
	output logic [7:0]         res_level,
	output logic               res_on_off,
	output logic               res_last
);
	import dlrc_pkg::*;
	logic [7:0]  on_level_q;
	logic [7:0]  lvl_q [CHANNELS];
	logic        on_q [CHANNELS];
	logic        act_q [CHANNELS];
	logic        tt_q [CHANNELS];
	logic        up_q [CHANNELS];
	logic [7:0]  tgt_q [CHANNELS];
	logic        sw_q [CHANNELS];
	logic [15:0] iv_q [CHANNELS];
	logic [15:0] cd_q [CHANNELS];

	// captured transaction
	logic [2:0]  cmd_q;
	logic [CW-1:0] ch_q;
	logic [7:0]  tl_q, rate_q, ss_q;
	logic [15:0] ttime_q;
	logic        dir_q, wsw_q;
	// pending move-to-level or step setup
	logic [7:0]  mtgt_q;
	logic        mup_q, nd_q;

	logic [8:0] ep_off;
	assign ep_off = {1'b0, endpoint} - 9'(FIRST_ENDPOINT);
	assign ep_ok = !ep_off[8] && (ep_off < 9'(CHANNELS));

	// move target from command
	logic [7:0] cur, tl_c, tgt_c, dist_c;
	logic [8:0] upsum;
	assign cur = lvl_q[ch_q];
	assign upsum = {1'b0, cur} + {1'b0, ss_q};
	always_comb begin
		tl_c = tl_q;
		if (tl_c < LEVEL_MIN) tl_c = LEVEL_MIN;
		if (tl_c > LEVEL_MAX) tl_c = LEVEL_MAX;
		if (cmd_q == CMD_STEP) begin
			if (dir_q) tgt_c = (upsum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : upsum[7:0];
			else tgt_c = ({1'b0, cur} < ({1'b0, ss_q} + 9'd1)) ? LEVEL_MIN : cur - ss_q;
		end else begin
			tgt_c = tl_c;
		end
		dist_c = (tgt_c > cur) ? tgt_c - cur : cur - tgt_c;
	end

	logic is_lvl, is_mv;
	assign is_lvl = (cmd_q == CMD_MOVE_TO) || (cmd_q == CMD_STEP);
	assign is_mv  = (cmd_q == CMD_MOVE);
	assign sts.need_div = (is_lvl && dist_c != 8'd0) || is_mv;

	// divider operands
	logic [23:0] num_c, quo;
	logic [15:0] den_c;
	logic [7:0]  rate_c;
	assign rate_c = (rate_q == 8'd0) ? 8'd1 : rate_q;
	assign num_c = is_mv ? 24'(RATE_NUM) : 24'(ttime_q) * 24'd100;
	assign den_c = is_mv ? 16'(rate_c) : 16'(dist_c);
	dlrc_div u_div (.clk(clk), .arst_n(arst_n), .go(ctl.div_go), .num(num_c),
		.den(den_c), .busy(sts.div_busy), .quo(quo));

	logic [15:0] iv_c;
	always_comb begin
		if (is_mv) iv_c = quo[15:0];
		else if (ttime_q == 16'd0) iv_c = IV_MIN;
		else if (quo > 24'hFFFF) iv_c = 16'hFFFF;
		else if (quo[15:0] < IV_MIN) iv_c = IV_MIN;
		else iv_c = quo[15:0];
	end

	// one tick step for channel sel
	logic [7:0] f_lv;
	logic f_on, f_act;
	logic [15:0] f_cd;
	always_comb begin
		f_lv = lvl_q[sel];
		f_on = on_q[sel];
		f_act = act_q[sel];
		f_cd = cd_q[sel];
		if (act_q[sel]) begin
			if (cd_q[sel] <= 16'd1) begin
				f_cd = iv_q[sel];
				if (tt_q[sel]) begin
					if (f_lv < tgt_q[sel]) f_lv = f_lv + 8'd1;
					else if (f_lv > tgt_q[sel]) f_lv = f_lv - 8'd1;
					if (sw_q[sel]) f_on = (f_lv != 8'd0);
					if (f_lv == tgt_q[sel]) f_act = 1'b0;
				end else begin
					if (up_q[sel] && f_lv < LEVEL_MAX) begin
						f_lv = f_lv + 8'd1;
						if (sw_q[sel]) f_on = 1'b1;
					end
					if (!up_q[sel] && f_lv > LEVEL_MIN) begin
						f_lv = f_lv - 8'd1;
						if (sw_q[sel] && f_lv != 8'd0) f_on = 1'b1;
					end
					if ((!up_q[sel] && f_lv <= LEVEL_MIN) || (up_q[sel] && f_lv >= LEVEL_MAX)) begin
						if (sw_q[sel] && !up_q[sel]) f_on = 1'b0;
						f_act = 1'b0;
					end
				end
			end else begin
				f_cd = cd_q[sel] - 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cmd_q <= cmd; ch_q <= ep_off[CW-1:0]; tl_q <= target_level;
			ttime_q <= transition_time; dir_q <= direction_up; rate_q <= move_rate;
			ss_q <= step_size; wsw_q <= with_on_off;
		end
		if (ctl.exec) begin
			mtgt_q <= tgt_c; mup_q <= (tgt_c > cur); nd_q <= is_lvl;
		end
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_level_q <= LEVEL_KEEP;
			for (int i = 0; i < CHANNELS; i++) begin
				lvl_q[i] <= LEVEL_MAX; on_q[i] <= 1'b0; act_q[i] <= 1'b0;
				tt_q[i] <= 1'b0; up_q[i] <= 1'b0; tgt_q[i] <= 8'd0; sw_q[i] <= 1'b0;
				iv_q[i] <= 16'd0; cd_q[i] <= 16'd0;
			end
		end else begin
			if (cfg_we) on_level_q <= cfg_wdata;
			if (ctl.exec) begin
				case (cmd_q)
					CMD_OFF: on_q[ch_q] <= 1'b0;
					CMD_ON: begin
						on_q[ch_q] <= 1'b1;
						if (on_level_q != LEVEL_KEEP) lvl_q[ch_q] <= on_level_q;
					end
					CMD_TOGGLE: begin
						on_q[ch_q] <= !on_q[ch_q];
						if (!on_q[ch_q] && on_level_q != LEVEL_KEEP) lvl_q[ch_q] <= on_level_q;
					end
					CMD_MOVE_TO, CMD_STEP: begin
						act_q[ch_q] <= 1'b0;
						if (dist_c == 8'd0 && wsw_q) on_q[ch_q] <= 1'b1;
					end
					CMD_MOVE: act_q[ch_q] <= 1'b0;
					CMD_STOP: act_q[ch_q] <= 1'b0;
					default: act_q[ch_q] <= act_q[ch_q];
				endcase
			end
			if (ctl.setup) begin
				act_q[ch_q] <= 1'b1;
				sw_q[ch_q] <= wsw_q;
				iv_q[ch_q] <= iv_c;
				cd_q[ch_q] <= iv_c;
				if (nd_q) begin
					tt_q[ch_q] <= 1'b1; up_q[ch_q] <= mup_q; tgt_q[ch_q] <= mtgt_q;
					if (wsw_q) on_q[ch_q] <= 1'b1;
				end else begin
					tt_q[ch_q] <= 1'b0; up_q[ch_q] <= dir_q;
					if (wsw_q && dir_q) on_q[ch_q] <= 1'b1;
				end
			end
			if (ctl.tick_ch) begin
				lvl_q[sel] <= f_lv; on_q[sel] <= f_on; act_q[sel] <= f_act; cd_q[sel] <= f_cd;
			end
		end
	end

	// result register
	logic [CW-1:0] rch;
	assign rch = ctl.emit_bad ? '0 : ((cmd_q == CMD_TICK) ? sel : ch_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else res_valid <= ctl.emit;
	end
	always_ff @(posedge clk) begin
		res_status  <= ctl.emit_bad ? ST_BAD_EP : ST_OK;
		res_channel <= 3'(rch);
		res_level   <= ctl.emit_bad ? 8'd0 : lvl_q[rch];
		res_on_off  <= ctl.emit_bad ? 1'b0 : on_q[rch];
		res_last    <= ctl.emit_last;
	end
endmodule

@@ test/tb_dimmer_level_ramp_controller_top.sv @@
`timescale 1ns / 1ps
module tb_dimmer_level_ramp_controller_top;
	import dlrc_pkg::*;

	localparam int NCH = 6;
	localparam int FIRST_EP = 1;

	typedef struct {
		logic [1:0] status;
		logic [2:0] channel;
		logic [7:0] level;
		logic       on_off;
		logic       last;
	} dim_result_t;

	typedef struct {
		logic [2:0]  cmd;
		logic [7:0]  endpoint;
		logic [7:0]  target_level;
		logic [15:0] transition_time;
		logic        direction_up;
		logic [7:0]  move_rate;
		logic [7:0]  step_size;
		logic        with_on_off;
	} dim_cmd_t;

	// Scoreboard: shadow dimmer state plus the queue of pending results
	class dimmer_scoreboard;
		logic [7:0]  on_lvl;
		logic [7:0]  lvl[NCH];
		logic        is_on[NCH];
		logic        active[NCH];
		logic        to_tgt[NCH];
		logic        up_dir[NCH];
		logic [7:0]  tgt[NCH];
		logic        sw[NCH];
		logic [15:0] ival[NCH];
		logic [15:0] cdown[NCH];
		dim_result_t pending[$];
		int          errors;

		function void init();
			on_lvl = 8'hFF;
			errors = 0;
			for (int c = 0; c < NCH; c++) begin
				lvl[c] = 8'd254; is_on[c] = 0; active[c] = 0; to_tgt[c] = 0;
				up_dir[c] = 0; tgt[c] = 0; sw[c] = 0; ival[c] = 0; cdown[c] = 0;
			end
		endfunction

		function void ramp_to_level(int c, int t, int tt, bit s);
			int span;
			longint iv;
			span = (t > lvl[c]) ? t - lvl[c] : lvl[c] - t;
			active[c] = 0;
			if (span == 0) begin
				if (s) is_on[c] = (t > 0);
				return;
			end
			iv = (tt == 0) ? 10 : (longint'(tt) * 100) / span;
			if (iv > 65535) iv = 65535;
			if (iv < 10) iv = 10;
			if (s && t > 0) is_on[c] = 1;
			active[c] = 1; to_tgt[c] = 1; up_dir[c] = (t > lvl[c]);
			tgt[c] = 8'(t); sw[c] = s; ival[c] = 16'(iv); cdown[c] = 16'(iv);
		endfunction

		function void advance_ramp(int c);
			int v;
			bit moved;
			v = lvl[c];
			if (to_tgt[c]) begin
				if (v < tgt[c]) v++;
				else if (v > tgt[c]) v--;
				lvl[c] = 8'(v);
				if (sw[c]) is_on[c] = (v > 0);
				if (v == tgt[c]) active[c] = 0;
			end else begin
				moved = 0;
				if (up_dir[c] && v < 254) begin v++; moved = 1; end
				if (!up_dir[c] && v > 1) begin v--; moved = 1; end
				if (moved) begin
					lvl[c] = 8'(v);
					if (sw[c] && v > 0) is_on[c] = 1;
				end
				if ((!up_dir[c] && v <= 1) || (up_dir[c] && v >= 254)) begin
					if (sw[c] && !up_dir[c]) is_on[c] = 0;
					active[c] = 0;
				end
			end
		endfunction

		function void push(logic [1:0] st, int ch, logic [7:0] lv, logic on, logic lst);
			dim_result_t r;
			r.status = st; r.channel = 3'(ch); r.level = lv; r.on_off = on; r.last = lst;
			pending.push_back(r);
		endfunction

		// note an accepted transaction and queue its expected results
		function void note_command(dim_cmd_t t);
			int c, v, rate;
			if (t.cmd == CMD_TICK) begin
				for (c = 0; c < NCH; c++) begin
					if (!active[c]) continue;
					if (cdown[c] <= 1) begin
						advance_ramp(c);
						cdown[c] = ival[c];
					end else cdown[c]--;
				end
				for (c = 0; c < NCH; c++) push(ST_OK, c, lvl[c], is_on[c], c == NCH - 1);
				return;
			end
			if (t.endpoint < FIRST_EP || t.endpoint - FIRST_EP >= NCH) begin
				push(ST_BAD_EP, 0, 8'd0, 1'b0, 1'b1);
				return;
			end
			c = t.endpoint - FIRST_EP;
			case (t.cmd)
				CMD_OFF: is_on[c] = 0;
				CMD_ON: begin
					is_on[c] = 1;
					if (on_lvl != LEVEL_KEEP) lvl[c] = on_lvl;
				end
				CMD_TOGGLE: begin
					is_on[c] = !is_on[c];
					if (is_on[c] && on_lvl != LEVEL_KEEP) lvl[c] = on_lvl;
				end
				CMD_MOVE_TO: begin
					v = t.target_level;
					if (v < 1) v = 1;
					if (v > 254) v = 254;
					ramp_to_level(c, v, t.transition_time, t.with_on_off);
				end
				CMD_MOVE: begin
					rate = (t.move_rate == 0) ? 1 : t.move_rate;
					if (t.with_on_off && t.direction_up) is_on[c] = 1;
					active[c] = 1; to_tgt[c] = 0; up_dir[c] = t.direction_up;
					sw[c] = t.with_on_off; ival[c] = 16'(1000 / rate);
					cdown[c] = 16'(1000 / rate);
				end
				CMD_STEP: begin
					v = lvl[c];
					if (t.direction_up) v = (v + t.step_size > 254) ? 254 : v + t.step_size;
					else v = (v < t.step_size + 1) ? 1 : v - t.step_size;
					ramp_to_level(c, v, t.transition_time, t.with_on_off);
				end
				default: active[c] = 0;
			endcase
			push(ST_OK, c, lvl[c], is_on[c], 1);
		endfunction

		function void check_result(dim_result_t a);
			dim_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result channel %0d", a.channel);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, a.status); errors++;
			end
			if (a.channel !== e.channel) begin
				$error("channel exp %0d got %0d", e.channel, a.channel); errors++;
			end
			if (a.level !== e.level) begin
				$error("level exp %0d got %0d", e.level, a.level); errors++;
			end
			if (a.on_off !== e.on_off) begin
				$error("on_off exp %0d got %0d", e.on_off, a.on_off); errors++;
			end
			if (a.last !== e.last) begin
				$error("last exp %0d got %0d", e.last, a.last); errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [2:0]  cmd = '0;
	logic [7:0]  endpoint = '0;
	logic [7:0]  target_level = '0;
	logic [15:0] transition_time = '0;
	logic        direction_up = 0;
	logic [7:0]  move_rate = '0;
	logic [7:0]  step_size = '0;
	logic        with_on_off = 0;
	logic        cfg_we = 0;
	logic [7:0]  cfg_wdata = '0;
	logic        strobe;
	logic [1:0]  status;
	logic [2:0]  channel;
	logic [7:0]  level;
	logic        on_off;
	logic        last;

	dimmer_scoreboard sb;
	bit idle_en;

	dimmer_level_ramp_controller_top #(.CHANNELS(NCH), .FIRST_ENDPOINT(FIRST_EP)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.endpoint(endpoint), .target_level(target_level),
		.transition_time(transition_time), .direction_up(direction_up),
		.move_rate(move_rate), .step_size(step_size), .with_on_off(with_on_off),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .strobe(strobe), .status(status),
		.channel(channel), .level(level), .on_off(on_off), .last(last)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// result monitor
	always @(posedge clk) begin
		dim_result_t r;
		if (arst_n && strobe) begin
			r.status = status; r.channel = channel; r.level = level;
			r.on_off = on_off; r.last = last;
			sb.check_result(r);
		end
	end

	// one transaction, held until accepted; start stays high until the next idle or drain
	task automatic send(dim_cmd_t t);
		if (idle_en)
			while ($urandom_range(99) < 35) begin
				start <= 0;
				@(posedge clk);
			end
		cmd <= t.cmd; endpoint <= t.endpoint; target_level <= t.target_level;
		transition_time <= t.transition_time; direction_up <= t.direction_up;
		move_rate <= t.move_rate; step_size <= t.step_size;
		with_on_off <= t.with_on_off;
		start <= 1;
		do @(posedge clk); while (busy);
		sb.note_command(t);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_on_level(logic [7:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.on_lvl = v;
		cfg_we <= 0;
	endtask

	function automatic dim_cmd_t mk(logic [2:0] c, logic [7:0] ep);
		dim_cmd_t t;
		t.cmd = c; t.endpoint = ep; t.target_level = 8'($urandom);
		t.transition_time = 16'($urandom_range(0, 20)); t.direction_up = 1'($urandom);
		t.move_rate = 8'($urandom_range(50, 255)); t.step_size = 8'($urandom);
		t.with_on_off = 1'($urandom);
		return t;
	endfunction

	function automatic dim_cmd_t rand_cmd();
		dim_cmd_t t;
		int r;
		r = $urandom_range(99);
		if (r < 50) t = mk(CMD_TICK, 8'($urandom));
		else t = mk(3'($urandom_range(0, 6)), 8'($urandom_range(0, 99) < 90 ?
			$urandom_range(FIRST_EP, FIRST_EP + NCH - 1) : $urandom));
		// mostly short ramps so ticks see them fire and finish
		if ($urandom_range(9) == 0) t.transition_time = 16'($urandom);
		if ($urandom_range(9) == 0) t.move_rate = 8'($urandom_range(0, 3));
		if ($urandom_range(4) == 0) t.step_size = 8'($urandom_range(0, 4));
		return t;
	endfunction

	initial begin
		dim_cmd_t t;
		sb = new();
		sb.init();
		idle_en = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every command, endpoint edges, field extremes
		send(mk(CMD_ON, 8'(FIRST_EP)));
		send(mk(CMD_OFF, 8'(FIRST_EP + NCH - 1)));
		send(mk(CMD_TOGGLE, 8'd2));
		send(mk(CMD_TOGGLE, 8'd2));
		send(mk(CMD_ON, 8'd0));
		send(mk(CMD_OFF, 8'(FIRST_EP + NCH)));
		send(mk(CMD_STOP, 8'hFF));
		t = mk(CMD_MOVE_TO, 8'd3); t.target_level = 0; t.transition_time = 0;
		t.with_on_off = 1; send(t);
		t = mk(CMD_MOVE_TO, 8'd4); t.target_level = 8'hFF; t.transition_time = 16'hFFFF;
		t.with_on_off = 1; send(t);
		t = mk(CMD_MOVE_TO, 8'd5); t.target_level = 254; t.with_on_off = 1; send(t);
		t = mk(CMD_MOVE, 8'd1); t.move_rate = 0; t.direction_up = 1; t.with_on_off = 1;
		send(t);
		t = mk(CMD_MOVE, 8'd2); t.move_rate = 8'hFF; t.direction_up = 0;
		t.with_on_off = 1; send(t);
		t = mk(CMD_STEP, 8'd6); t.step_size = 8'hFF; t.direction_up = 0; send(t);
		t = mk(CMD_STEP, 8'd5); t.step_size = 8'hFF; t.direction_up = 1; send(t);
		repeat (8) send(mk(CMD_TICK, 8'($urandom)));
		send(mk(CMD_STOP, 8'd2));
		write_on_level(8'd0);
		send(mk(CMD_ON, 8'd1));
		send(mk(CMD_TOGGLE, 8'd3));

		// random phases across on_level settings
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_on_level(8'd128);
				1: write_on_level(8'hFF);
				2: write_on_level(8'd254);
				default: write_on_level(8'($urandom));
			endcase
			for (int i = 0; i < 80; i++) begin
				idle_en = (ph != 1);
				send(rand_cmd());
			end
		end
		drain();
		if (sb.errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
